[design/bly_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bly_pkg
// Types and constants shared by the bully election node modules.
// ----------------------------------------------------------------------------
package bly_pkg;

    localparam int ID_SPACE   = 32;
    localparam int MAX_NODES  = 32;
    localparam int ID_W       = 5;
    localparam int CNT_W      = 6;
    localparam int TICK_W     = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int PADDR_W    = 4;

    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_NODES < ID_SPACE) ? MAX_NODES : ID_SPACE);

    typedef enum logic [1:0] {
        KIND_MSG       = 2'd0,
        KIND_LINK_UP   = 2'd1,
        KIND_LINK_DOWN = 2'd2,
        KIND_TICK      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MSG_ELECTION = 2'd0,
        MSG_OK       = 2'd1,
        MSG_WINNER   = 2'd2
    } msg_t;

    typedef enum logic [1:0] {
        REG_OWN_ID     = 2'd0,
        REG_NODE_COUNT = 2'd1,
        REG_WAIT_TICKS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]   own_id;
        logic [CNT_W-1:0]  node_count;
        logic [TICK_W-1:0] wait_ticks;
    } cfg_t;

    // One event's work for the back end: optional OK, then a broadcast.
    typedef struct packed {
        logic                ok_pend;
        logic [ID_W-1:0]     ok_dest;
        logic [ID_SPACE-1:0] mask;
        logic [1:0]          bc_msg;
        logic                leader_known;
        logic [ID_W-1:0]     leader_id;
        logic                electing;
    } desc_t;

endpackage

[design/bly_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bly_front
// Accepts events, updates election state, emits a send descriptor per event.
// ----------------------------------------------------------------------------
module bly_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bly_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_kind,
    input  logic [4:0]           in_peer,
    input  logic [1:0]           in_msg_type,
    input  logic                 q_full,
    output logic                 q_push,
    output bly_pkg::desc_t       q_desc
);
    import bly_pkg::*;

    logic [ID_SPACE-1:0] link_alive_reg, link_alive_next;
    logic                leader_valid_reg, leader_valid_next;
    logic [ID_W-1:0]     leader_id_reg, leader_id_next;
    logic                electing_reg, electing_next;
    logic [TICK_W-1:0]   countdown_reg, countdown_next;

    logic [CNT_W-1:0]    eff_cnt;
    logic                peer_ok;
    logic                peer_low;
    logic                send_ok;
    logic                start;
    logic                do_start;
    logic                do_claim;
    logic [ID_SPACE-1:0] bc_mask;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb begin
        eff_cnt  = (cfg.node_count > CNT_CAP) ? CNT_CAP : cfg.node_count;
        peer_ok  = ({1'b0, in_peer} < eff_cnt) && (in_peer != cfg.own_id);
        peer_low = in_peer < cfg.own_id;

        link_alive_next   = link_alive_reg;
        leader_valid_next = leader_valid_reg;
        leader_id_next    = leader_id_reg;
        electing_next     = electing_reg;
        countdown_next    = countdown_reg;
        send_ok  = 1'b0;
        start    = 1'b0;
        do_claim = 1'b0;

        case (kind_t'(in_kind))
            KIND_MSG: begin
                if (peer_ok) begin
                    case (in_msg_type)
                        MSG_ELECTION: begin
                            if (peer_low) begin
                                send_ok = 1'b1;
                                start   = 1'b1;
                            end
                        end
                        MSG_OK: begin
                            electing_next = 1'b0;
                        end
                        MSG_WINNER: begin
                            leader_valid_next = 1'b1;
                            leader_id_next    = in_peer;
                            start             = peer_low;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_LINK_UP: begin
                if (peer_ok) begin
                    link_alive_next[in_peer] = 1'b1;
                    start = peer_low;
                end
            end
            KIND_LINK_DOWN: begin
                if (peer_ok) begin
                    link_alive_next[in_peer] = 1'b0;
                    start = leader_valid_reg && (leader_id_reg == in_peer);
                end
            end
            KIND_TICK: begin
                if (electing_reg) begin
                    if (countdown_reg <= TICK_W'(1)) begin
                        do_claim = 1'b1;
                    end else begin
                        countdown_next = countdown_reg - TICK_W'(1);
                    end
                end else if (!leader_valid_reg) begin
                    start = 1'b1;
                end
            end
            default: ;
        endcase

        do_start = start && !electing_reg;
        if (do_start) begin
            electing_next  = 1'b1;
            countdown_next = cfg.wait_ticks;
        end
        if (do_claim) begin
            electing_next     = 1'b0;
            leader_valid_next = 1'b1;
            leader_id_next    = cfg.own_id;
        end

        for (int i = 0; i < ID_SPACE; i++) begin
            bc_mask[i] = link_alive_next[i] && (CNT_W'(i) < eff_cnt) &&
                ((do_start && (CNT_W'(i) > {1'b0, cfg.own_id})) ||
                 (do_claim && (ID_W'(i) != cfg.own_id)));
        end

        q_desc.ok_pend      = send_ok;
        q_desc.ok_dest      = in_peer;
        q_desc.mask         = bc_mask;
        q_desc.bc_msg       = do_claim ? MSG_WINNER : MSG_ELECTION;
        q_desc.leader_known = leader_valid_next;
        q_desc.leader_id    = leader_id_next;
        q_desc.electing     = electing_next;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            link_alive_reg   <= '0;
            leader_valid_reg <= 1'b0;
            leader_id_reg    <= '0;
            electing_reg     <= 1'b0;
            countdown_reg    <= '0;
        end else if (q_push) begin
            link_alive_reg   <= link_alive_next;
            leader_valid_reg <= leader_valid_next;
            leader_id_reg    <= leader_id_next;
            electing_reg     <= electing_next;
            countdown_reg    <= countdown_next;
        end
    end

endmodule

[design/bly_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bly_fifo
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module bly_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bly_pkg::desc_t wr_data,
    input  logic           pop,
    output bly_pkg::desc_t rd_data,
    output logic           full,
    output logic           empty
);
    import bly_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    desc_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full    = count_reg == (PTR_W+1)'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[design/bly_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bly_back
// Walks a descriptor: OK beat, a beat per set mask bit (low id first), else one status beat.
// ----------------------------------------------------------------------------
module bly_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  bly_pkg::desc_t q_desc,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_send_valid,
    output logic [4:0]     out_dest,
    output logic [1:0]     out_msg,
    output logic           out_leader_known,
    output logic [4:0]     out_leader_id,
    output logic           out_electing,
    output logic           out_last
);
    import bly_pkg::*;

    logic                busy_reg;
    desc_t               work_reg, work_next;

    logic                m_valid_reg;
    logic                send_valid_reg, send_valid_next;
    logic [ID_W-1:0]     dest_reg, dest_next;
    logic [1:0]          msg_reg, msg_next;
    logic                last_reg, last_next;
    logic                leader_known_reg;
    logic [ID_W-1:0]     leader_id_reg;
    logic                electing_reg;

    logic                emit;
    logic [ID_W-1:0]     low_idx;
    logic [ID_SPACE-1:0] mask_rest;

    assign q_pop = !busy_reg && !q_empty;
    assign emit  = busy_reg && (!m_valid_reg || out_ready);

    always_comb begin
        low_idx = '0;
        for (int i = ID_SPACE - 1; i >= 0; i--) begin
            if (work_reg.mask[i]) begin
                low_idx = ID_W'(i);
            end
        end
        mask_rest = work_reg.mask & (work_reg.mask - 1'b1);

        work_next       = work_reg;
        send_valid_next = 1'b0;
        dest_next       = '0;
        msg_next        = MSG_ELECTION;
        last_next       = 1'b1;
        if (work_reg.ok_pend) begin
            work_next.ok_pend = 1'b0;
            send_valid_next   = 1'b1;
            dest_next         = work_reg.ok_dest;
            msg_next          = MSG_OK;
            last_next         = work_reg.mask == '0;
        end else if (work_reg.mask != '0) begin
            work_next.mask  = mask_rest;
            send_valid_next = 1'b1;
            dest_next       = low_idx;
            msg_next        = work_reg.bc_msg;
            last_next       = mask_rest == '0;
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            work_reg <= q_desc;
        end else if (emit) begin
            work_reg <= work_next;
        end
        if (emit) begin
            send_valid_reg   <= send_valid_next;
            dest_reg         <= dest_next;
            msg_reg          <= msg_next;
            last_reg         <= last_next;
            leader_known_reg <= work_reg.leader_known;
            leader_id_reg    <= work_reg.leader_id;
            electing_reg     <= work_reg.electing;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
            end else if (emit && last_next) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = m_valid_reg;
    assign out_send_valid   = send_valid_reg;
    assign out_dest         = dest_reg;
    assign out_msg          = msg_reg;
    assign out_last         = last_reg;
    assign out_leader_known = leader_known_reg;
    assign out_leader_id    = leader_id_reg;
    assign out_electing     = electing_reg;

endmodule

[design/bully_leader_election_node.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bully_leader_election_node
// One node of a bully leader election with an APB configuration port.
// ----------------------------------------------------------------------------
// First result beat of an event passes the queue, work register and output register.
// Throughput: the back end loads one event from a 2-entry queue only when idle, then sends
// its messages one per cycle while m_ready accepts them (up to 31 per event).
// Reset: synchronous active-low aresetn clears links, leader, election state
// and registers (own_id 0, node_count 1, wait_ticks 2); no clearing pass.
module bully_leader_election_node (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [4:0]  s_peer,
    input  logic [1:0]  s_msg_type,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_valid,
    output logic [4:0]  m_dest,
    output logic [1:0]  m_out_msg,
    output logic        m_leader_known,
    output logic [4:0]  m_leader_id,
    output logic        m_electing,
    output logic        m_last
);
    import bly_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t wr_idx;
    logic     cfg_wr;
    logic     q_push, q_pop, q_full, q_empty;
    desc_t    q_wr_desc, q_rd_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_id     <= '0;
            cfg_reg.node_count <= CNT_W'(1);
            cfg_reg.wait_ticks <= TICK_W'(2);
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_OWN_ID:     cfg_reg.own_id     <= pwdata[ID_W-1:0];
                REG_NODE_COUNT: cfg_reg.node_count <= pwdata[CNT_W-1:0];
                REG_WAIT_TICKS: cfg_reg.wait_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_OWN_ID:     prdata = {{(32-ID_W){1'b0}}, cfg_reg.own_id};
            REG_NODE_COUNT: prdata = {{(32-CNT_W){1'b0}}, cfg_reg.node_count};
            REG_WAIT_TICKS: prdata = {{(32-TICK_W){1'b0}}, cfg_reg.wait_ticks};
            default:        prdata = '0;
        endcase
    end

    bly_front u_front (
        .clk         (aclk),
        .rst_n       (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_kind     (s_kind),
        .in_peer     (s_peer),
        .in_msg_type (s_msg_type),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_wr_desc)
    );

    bly_fifo u_fifo (
        .clk     (aclk),
        .rst_n   (aresetn),
        .push    (q_push),
        .wr_data (q_wr_desc),
        .pop     (q_pop),
        .rd_data (q_rd_desc),
        .full    (q_full),
        .empty   (q_empty)
    );

    bly_back u_back (
        .clk              (aclk),
        .rst_n            (aresetn),
        .q_empty          (q_empty),
        .q_desc           (q_rd_desc),
        .q_pop            (q_pop),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_send_valid   (m_send_valid),
        .out_dest         (m_dest),
        .out_msg          (m_out_msg),
        .out_leader_known (m_leader_known),
        .out_leader_id    (m_leader_id),
        .out_electing     (m_electing),
        .out_last         (m_last)
    );

endmodule

[design/bly_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bly_checker
// Port-level checks for the bully election node, bound to the top level.
// ----------------------------------------------------------------------------
module bly_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_send_valid,
    input logic [4:0] m_dest,
    input logic [1:0] m_out_msg,
    input logic       m_leader_known,
    input logic [4:0] m_leader_id,
    input logic       m_electing,
    input logic       m_last
);
    import bly_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dest) && $stable(m_out_msg)
            && $stable(m_send_valid) && $stable(m_last))
        else $error("result beat changed while stalled");

    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_valid |-> m_last && m_dest == '0 && m_out_msg == MSG_ELECTION)
        else $error("status beat malformed");

    a_winner_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_valid && m_out_msg == MSG_WINNER |-> m_leader_known && !m_electing)
        else $error("winner sent without leadership");

    a_vote_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_valid && (m_out_msg == MSG_ELECTION || m_out_msg == MSG_OK)
            |-> m_electing)
        else $error("election traffic while not electing");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bully_leader_election_node bly_checker u_bly_checker (.*);
